/* hdl/tct_pkg.sv */
// shared types, codes and character tables for the text case transform
// no dependencies; imported by tct_xform and text_case_transform
package tct_pkg;

    // operation codes held in the mode register
    localparam logic [2:0] MODE_UPPER    = 3'd0;
    localparam logic [2:0] MODE_LOWER    = 3'd1;
    localparam logic [2:0] MODE_SIMPLIFY = 3'd2;
    localparam logic [2:0] MODE_WORDS    = 3'd3;
    localparam logic [2:0] MODE_FIRST    = 3'd4;

    // punctuation that decides word starts
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // cyrillic yo in the 1251 positions
    localparam logic [7:0] CH_YO_UP  = 8'hA8;
    localparam logic [7:0] CH_YO_LOW = 8'hB8;

    // position count saturates here
    localparam logic [1:0] POS_MAX = 2'd2;

    // accented pairs in the 437 positions, lower and upper form
    localparam int ACCENT_PAIRS = 8;
    localparam logic [7:0] ACC_LOW [ACCENT_PAIRS] =
        '{8'd129, 8'd164, 8'd132, 8'd134, 8'd130, 8'd148, 8'd135, 8'd145};
    localparam logic [7:0] ACC_UP [ACCENT_PAIRS] =
        '{8'd154, 8'd165, 8'd142, 8'd143, 8'd144, 8'd153, 8'd128, 8'd146};

    // string history kept between characters
    typedef struct packed {
        logic [7:0] prev_one;
        logic [7:0] prev_two;
        logic [1:0] position_count;
        logic       first_word_done;
    } tct_hist_t;

    // latin or cyrillic lower case letter, yo included
    function automatic logic is_lower_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || c >= 8'hE0 || c == CH_YO_LOW;
    endfunction

    function automatic logic [7:0] to_upper_plain(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= "a" && c <= "z") || c >= 8'hE0) begin
            r = c - 8'h20;
        end else if (c == CH_YO_LOW) begin
            r = CH_YO_UP;
        end
        return r;
    endfunction

    function automatic logic [7:0] to_lower_plain(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= "A" && c <= "Z") || (c >= 8'hC0 && c <= 8'hDF)) begin
            r = c + 8'h20;
        end else if (c == CH_YO_UP) begin
            r = CH_YO_LOW;
        end
        return r;
    endfunction

    // upper accented form, or the byte itself
    function automatic logic [7:0] accent_up(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        for (int i = 0; i < ACCENT_PAIRS; i++) begin
            if (ACC_LOW[i] == c) begin
                r = ACC_UP[i];
            end
        end
        return r;
    endfunction

    // lower accented form, or the byte itself
    function automatic logic [7:0] accent_down(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        for (int i = 0; i < ACCENT_PAIRS; i++) begin
            if (ACC_UP[i] == c) begin
                r = ACC_LOW[i];
            end
        end
        return r;
    endfunction

    // lower case, then accented letters to plain ascii
    function automatic logic [7:0] simplify_byte(input logic [7:0] c);
        logic [7:0] l;
        logic [7:0] r;
        l = to_lower_plain(c);
        case (l)
            8'd129, 8'd150, 8'd151, 8'd154, 8'd163: r = "u";
            8'd152: r = "y";
            8'd164, 8'd165: r = "n";
            8'd131, 8'd132, 8'd133, 8'd134, 8'd142, 8'd143,
            8'd145, 8'd146, 8'd160: r = "a";
            8'd130, 8'd136, 8'd137, 8'd138, 8'd144: r = "e";
            8'd139, 8'd140, 8'd141, 8'd161: r = "i";
            8'd147, 8'd148, 8'd149, 8'd153, 8'd162: r = "o";
            8'd128, 8'd135: r = "c";
            default: r = l;
        endcase
        return r;
    endfunction

endpackage

/* hdl/text_case_transform.sv */
// top level of the text case transform: input register, transform, result register
// depends on tct_pkg and tct_xform
//
// Rewrites a byte stream one character per transfer under the mode in the
// configuration register (0 upper, 1 lower, 2 simplify, 3 capitalize words,
// 4 capitalize first word; other codes pass bytes unchanged). The block is a
// two-register pipeline: a character is captured in the input register, mapped
// by the transform as it moves to the result register, and the string history
// (last two output characters, position count, first-word flag) updates in the
// same cycle. One character is accepted every cycle while the result side keeps
// up; each character passes the input register and then the result register
// before its result is offered. last marks the end of a string and clears the
// history after that character. Write the mode only while the block is idle.
module text_case_transform import tct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_case_mode,
    // input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_last_in,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic       m_last_out
);

    logic [2:0] mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    tct_hist_t  hist_reg;
    tct_hist_t  hist_next;
    logic [7:0] char_next;
    logic       advance;

    // handshakes
    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_UPPER;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_case_mode;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
            in_last_reg <= s_last_in;
        end
    end

    // character transform
    tct_xform u_xform (
        .char_in   (in_char_reg),
        .last_in   (in_last_reg),
        .case_mode (mode_reg),
        .hist      (hist_reg),
        .char_out  (char_next),
        .hist_next (hist_next)
    );

    // string history advances with each character moved to the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (advance) begin
            hist_reg <= hist_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_char_reg <= char_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_char_out = out_char_reg;
    assign m_last_out = out_last_reg;

endmodule

/* hdl/tct_xform.sv */
// per-character transform: maps one byte under the current mode and history
// depends on tct_pkg; instantiated by text_case_transform
module tct_xform import tct_pkg::*; (
    input  logic [7:0] char_in,
    input  logic       last_in,
    input  logic [2:0] case_mode,
    input  tct_hist_t  hist,
    output logic [7:0] char_out,
    output tct_hist_t  hist_next
);

    logic word_start;
    logic done_next;

    // word start from the two-character history
    always_comb begin
        word_start = (hist.position_count == 2'd0)
            || hist.prev_one == CH_SPACE || hist.prev_one == CH_QUOTE
            || (hist.prev_one == CH_APOS && hist.position_count == POS_MAX
                && (hist.prev_two == CH_SPACE || hist.prev_two == CH_COMMA));
    end

    // character mapping per mode
    always_comb begin
        char_out  = char_in;
        done_next = hist.first_word_done;
        case (case_mode)
            MODE_UPPER: begin
                char_out = accent_up(to_upper_plain(char_in));
            end
            MODE_LOWER: begin
                char_out = accent_down(to_lower_plain(char_in));
            end
            MODE_SIMPLIFY: begin
                char_out = simplify_byte(char_in);
            end
            MODE_WORDS: begin
                if (word_start) begin
                    char_out = accent_up(to_upper_plain(char_in));
                end
            end
            MODE_FIRST: begin
                if (!hist.first_word_done && word_start) begin
                    if (is_lower_letter(char_in)) begin
                        char_out = to_upper_plain(char_in);
                    end else begin
                        char_out = accent_up(char_in);
                    end
                    // anything but a space or quote ends the first word
                    if (char_in != CH_SPACE && char_in != CH_QUOTE) begin
                        done_next = 1'b1;
                    end
                end
            end
            default: begin
                char_out = char_in;
            end
        endcase
    end

    // history update, cleared at end of string
    always_comb begin
        if (last_in) begin
            hist_next = '0;
        end else begin
            hist_next.prev_two        = hist.prev_one;
            hist_next.prev_one        = char_out;
            hist_next.position_count  = (hist.position_count < POS_MAX)
                ? hist.position_count + 2'd1 : hist.position_count;
            hist_next.first_word_done = done_next;
        end
    end

endmodule
